// ===== sv/assert_macros.svh =====
// assertion macros included by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// implication checked in the same cycle
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define ASSERT_ALWAYS(label, prop, msg)
`define ASSERT_IMPL(label, ante, cons, msg)
`endif
`endif

// ===== sv/mbet_pkg.sv =====
// types, constants and helpers of the mandelbrot escape-time pixel unit
package mbet_pkg;

  // fixed-point format of c and z
  localparam int unsigned FracBits = 28;
  localparam logic signed [65:0] EscLimit = 66'sd4 <<< FracBits;

  // register reset values
  localparam logic signed [31:0] MinReRst  = -32'sd671088640;
  localparam logic signed [31:0] ReStepRst = 32'sd7895161;
  localparam logic signed [31:0] MaxImRst  = 32'sd156587349;
  localparam logic signed [31:0] ImStepRst = 32'sd8030223;
  localparam logic [16:0] MaxIterRst  = 17'd500;
  localparam logic [15:0] RowWidthRst = 16'd120;

  // colour gradient constants
  localparam logic [7:0] ColorInside = 8'd16;
  localparam logic [7:0] BaseBand1   = 8'd21;
  localparam logic [7:0] BaseBand2   = 8'd51;
  localparam logic [7:0] BaseBand3   = 8'd87;

  // glyphs
  localparam logic [6:0] GlyphInside = 7'd35;  // '#'
  localparam logic [6:0] GlyphColor  = 7'd42;  // '*'

  // register index on the config port
  typedef enum logic [2:0] {
    RegMinRe    = 3'd0,
    RegReStep   = 3'd1,
    RegMaxIm    = 3'd2,
    RegImStep   = 3'd3,
    RegMaxIter  = 3'd4,
    RegRowWidth = 3'd5,
    RegColorEn  = 3'd6
  } reg_idx_e;

  // sequencer states
  typedef enum logic [3:0] {
    StIdle,
    StCre,
    StCim,
    StCimw,
    StSqr,
    StSqi,
    StXpr,
    StCol0,
    StCol1,
    StDiv,
    StDone
  } state_e;

  // clamp a wide signed value to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (!v[65] && (|v[64:31])) begin
      r = 32'sh7fff_ffff;
    end else if (v[65] && !(&v[64:31])) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // ascii ramp " .-+*%@" indexed by count mod 7
  function automatic logic [6:0] ramp_glyph(input logic [2:0] idx);
    logic [6:0] g;
    unique case (idx)
      3'd0:    g = 7'd32;
      3'd1:    g = 7'd46;
      3'd2:    g = 7'd45;
      3'd3:    g = 7'd43;
      3'd4:    g = 7'd42;
      3'd5:    g = 7'd37;
      3'd6:    g = 7'd64;
      default: g = 7'd32;
    endcase
    return g;
  endfunction

endpackage

// ===== sv/mandelbrot_escape_time_pixel.sv =====
// mandelbrot escape-time pixel unit: one shared multiplier under a sequencer
//
// usage: a pixel request (column, row) enters on the s_axis channel; the
// result (iteration count, inside flag, palette code, glyph) leaves on the
// m_axis channel, with tlast marking the last column of a row. the view and
// iteration limit are set through the apb port; the user must set them only
// while the unit is idle, which the block itself does not enforce.
// the one 32x32 multiplier is used three times per z update (zr*zr, zi*zi,
// zr*zi), after the point c is formed in the StCre, StCim and StCimw states,
// and the palette code takes a restoring divide for a 7-bit quotient that a
// pixel at the limit skips; the default limit is 500. one pixel is worked on
// at a time; s_axis_tready is high only while the sequencer is idle, so the
// next request is taken only after a result is loaded and it is idle again.
// the finished result sits in an output register, so a stalled receiver
// holds the result there while the next request is already accepted; the
// sequencer waits at its end only if that register is still full.
// reset: registers return to their default view (limit 500, row width 120,
// colour on), the sequencer goes idle and the output register empties.
`include "assert_macros.svh"

module mandelbrot_escape_time_pixel (
  input  logic        clk_i,
  input  logic        rst_ni,
  // pixel request
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] col, [31:16] row
  // pixel result
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [16:0] iterations, [17] inside_res, [25:18] color_code, [32:26] glyph, zero pad
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tlast,   // end_of_row
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mbet_pkg::*;

  // configuration registers
  logic signed [31:0] min_re_q, re_step_q, max_im_q, im_step_q;
  logic [16:0] max_iter_q;
  logic [15:0] row_width_q;
  logic        color_en_q;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_re_q    <= MinReRst;
      re_step_q   <= ReStepRst;
      max_im_q    <= MaxImRst;
      im_step_q   <= ImStepRst;
      max_iter_q  <= MaxIterRst;
      row_width_q <= RowWidthRst;
      color_en_q  <= 1'b1;
    end else if (cfg_we) begin
      case (paddr[4:2])
        RegMinRe:    min_re_q    <= pwdata;
        RegReStep:   re_step_q   <= pwdata;
        RegMaxIm:    max_im_q    <= pwdata;
        RegImStep:   im_step_q   <= pwdata;
        RegMaxIter:  max_iter_q  <= pwdata[16:0];
        RegRowWidth: row_width_q <= pwdata[15:0];
        RegColorEn:  color_en_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (paddr[4:2])
      RegMinRe:    prdata = min_re_q;
      RegReStep:   prdata = re_step_q;
      RegMaxIm:    prdata = max_im_q;
      RegImStep:   prdata = im_step_q;
      RegMaxIter:  prdata = {15'd0, max_iter_q};
      RegRowWidth: prdata = {16'd0, row_width_q};
      RegColorEn:  prdata = {31'd0, color_en_q};
      default:     prdata = 32'd0;
    endcase
  end

  // sequencer and datapath state
  state_e state_q, state_d;
  logic [15:0] col_q, col_d, row_q, row_d;
  logic signed [31:0] c_re_q, c_re_d, c_im_q, c_im_d;
  logic signed [31:0] zr_q, zr_d, zi_q, zi_d;
  logic [16:0] n_q, n_d;
  logic [2:0]  mod7_q, mod7_d;
  logic        upd_q, upd_d;
  logic signed [63:0] sr_q, sr_d;
  logic signed [63:0] prod_q, prod_d;
  logic signed [31:0] mul_a, mul_b;

  // colour datapath
  logic [23:0] t_q, t_d, b_q, b_d;
  logic [22:0] a_q, a_d, e_q, e_d;
  logic [28:0] n3k_q, n3k_d;
  logic [28:0] rem_q, rem_d;
  logic [22:0] den_q, den_d;
  logic [7:0]  base_q, base_d;
  logic [6:0]  quo_q, quo_d;
  logic [2:0]  k_q, k_d;
  logic [28:0] trial;

  // output register
  logic        out_valid_q, out_valid_d;
  logic [16:0] out_iter_q, out_iter_d;
  logic        out_inside_q, out_inside_d;
  logic [7:0]  out_color_q, out_color_d;
  logic [6:0]  out_glyph_q, out_glyph_d;
  logic        out_eor_q, out_eor_d;

  // derived values
  logic signed [63:0] si, xprod;
  logic signed [65:0] cre_sum, cim_diff, zr_sum, zi_sum, mag;
  logic        esc, at_limit;

  assign si       = prod_q >>> FracBits;
  assign xprod    = prod_q >>> (FracBits - 1);
  assign cre_sum  = 66'(min_re_q) + 66'(prod_q);
  assign cim_diff = 66'(max_im_q) - 66'(prod_q);
  assign zr_sum   = 66'(sr_q) - 66'(si) + 66'(c_re_q);
  assign zi_sum   = 66'(xprod) + 66'(c_im_q);
  assign mag      = 66'(sr_q) + 66'(si);
  assign esc      = mag > EscLimit;
  assign at_limit = n_q >= max_iter_q;
  assign trial    = 29'(den_q) << k_q;

  // shared multiplier, registered
  assign prod_d = mul_a * mul_b;

  // next state and datapath control
  always_comb begin
    state_d      = state_q;
    col_d        = col_q;
    row_d        = row_q;
    c_re_d       = c_re_q;
    c_im_d       = c_im_q;
    zr_d         = zr_q;
    zi_d         = zi_q;
    n_d          = n_q;
    mod7_d       = mod7_q;
    upd_d        = 1'b0;
    sr_d         = sr_q;
    t_d          = t_q;
    a_d          = a_q;
    b_d          = b_q;
    e_d          = e_q;
    n3k_d        = n3k_q;
    rem_d        = rem_q;
    den_d        = den_q;
    base_d       = base_q;
    quo_d        = quo_q;
    k_d          = k_q;
    out_valid_d  = out_valid_q & ~m_axis_tready;
    out_iter_d   = out_iter_q;
    out_inside_d = out_inside_q;
    out_color_d  = out_color_q;
    out_glyph_d  = out_glyph_q;
    out_eor_d    = out_eor_q;
    mul_a        = zr_q;
    mul_b        = zi_q;
    unique case (state_q)
      // take a request
      StIdle: begin
        if (s_axis_tvalid) begin
          col_d   = s_axis_tdata[15:0];
          row_d   = s_axis_tdata[31:16];
          zr_d    = '0;
          zi_d    = '0;
          n_d     = '0;
          mod7_d  = '0;
          state_d = StCre;
        end
      end
      // col * re_step
      StCre: begin
        mul_a   = signed'({16'd0, col_q});
        mul_b   = re_step_q;
        state_d = StCim;
      end
      // c_re, then row * im_step
      StCim: begin
        c_re_d  = sat32(cre_sum);
        mul_a   = signed'({16'd0, row_q});
        mul_b   = im_step_q;
        state_d = StCimw;
      end
      StCimw: begin
        c_im_d  = sat32(cim_diff);
        state_d = StSqr;
      end
      // finish pending zi update, check limit, zr*zr
      StSqr: begin
        if (upd_q) begin
          zi_d = sat32(zi_sum);
        end
        if (at_limit) begin
          state_d = StCol0;
        end else begin
          mul_a   = zr_q;
          mul_b   = zr_q;
          state_d = StSqi;
        end
      end
      // zi*zi
      StSqi: begin
        sr_d    = si;
        mul_a   = zi_q;
        mul_b   = zi_q;
        state_d = StXpr;
      end
      // escape test, zr update, zr*zi
      StXpr: begin
        mul_a = zr_q;
        mul_b = zi_q;
        if (esc) begin
          state_d = StCol0;
        end else begin
          zr_d    = sat32(zr_sum);
          n_d     = n_q + 17'd1;
          mod7_d  = (mod7_q == 3'd6) ? 3'd0 : mod7_q + 3'd1;
          upd_d   = 1'b1;
          state_d = StSqr;
        end
      end
      // gradient scaled terms
      StCol0: begin
        t_d     = 24'(n_q) * 24'd100;
        a_d     = 23'(max_iter_q) * 23'd33;
        b_d     = 24'(max_iter_q) * 24'd66;
        e_d     = 23'(max_iter_q) * 23'd34;
        n3k_d   = 29'(n_q) * 29'd3000;
        state_d = StCol1;
      end
      // band select
      StCol1: begin
        quo_d = '0;
        k_d   = 3'd6;
        if (t_q < 24'(a_q)) begin
          rem_d  = n3k_q;
          den_d  = a_q;
          base_d = BaseBand1;
        end else if (t_q < b_q) begin
          rem_d  = 29'(t_q - 24'(a_q)) * 29'd36;
          den_d  = a_q;
          base_d = BaseBand2;
        end else begin
          rem_d  = 29'(t_q - b_q) * 29'd109;
          den_d  = e_q;
          base_d = BaseBand3;
        end
        state_d = at_limit ? StDone : StDiv;
      end
      // restoring divide, one quotient bit per cycle
      StDiv: begin
        if (rem_q >= trial) begin
          rem_d        = rem_q - trial;
          quo_d[k_q]   = 1'b1;
        end
        if (k_q == 3'd0) begin
          state_d = StDone;
        end else begin
          k_d = k_q - 3'd1;
        end
      end
      // hand over to the output register
      StDone: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d  = 1'b1;
          out_iter_d   = n_q;
          out_inside_d = at_limit;
          out_color_d  = at_limit ? ColorInside : base_q + {1'b0, quo_q};
          if (at_limit) begin
            out_glyph_d = GlyphInside;
          end else if (color_en_q) begin
            out_glyph_d = GlyphColor;
          end else begin
            out_glyph_d = ramp_glyph(mod7_q);
          end
          out_eor_d = (row_width_q != 16'd0) && (col_q == row_width_q - 16'd1);
          state_d   = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      upd_q       <= 1'b0;
      out_valid_q <= 1'b0;
      mod7_q      <= '0;
      n_q         <= '0;
    end else begin
      state_q     <= state_d;
      upd_q       <= upd_d;
      out_valid_q <= out_valid_d;
      mod7_q      <= mod7_d;
      n_q         <= n_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    col_q        <= col_d;
    row_q        <= row_d;
    c_re_q       <= c_re_d;
    c_im_q       <= c_im_d;
    zr_q         <= zr_d;
    zi_q         <= zi_d;
    sr_q         <= sr_d;
    prod_q       <= prod_d;
    t_q          <= t_d;
    a_q          <= a_d;
    b_q          <= b_d;
    e_q          <= e_d;
    n3k_q        <= n3k_d;
    rem_q        <= rem_d;
    den_q        <= den_d;
    base_q       <= base_d;
    quo_q        <= quo_d;
    k_q          <= k_d;
    out_iter_q   <= out_iter_d;
    out_inside_q <= out_inside_d;
    out_color_q  <= out_color_d;
    out_glyph_q  <= out_glyph_d;
    out_eor_q    <= out_eor_d;
  end

  // ports
  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_glyph_q, out_color_q, out_inside_q, out_iter_q};
  assign m_axis_tlast  = out_eor_q;

  // checks
  `ASSERT_IMPL(a_count_in_limit, state_q == StSqr, n_q <= max_iter_q, "count passed limit")
  `ASSERT_ALWAYS(a_mod7_range, mod7_q <= 3'd6, "mod 7 counter out of range")
  `ASSERT_IMPL(a_color_range, (state_q == StDone) && !at_limit,
               (base_q + {1'b0, quo_q} >= 8'd21) && (base_q + {1'b0, quo_q} <= 8'd195),
               "gradient code out of range")
  `ASSERT_IMPL(a_out_from_done, $rose(out_valid_q), $past(state_q) == StDone,
               "result loaded outside done state")

endmodule
